### hw/rtl/ilp_pkg.sv
// ilp_pkg: shared types and constants of the integer literal parser
// used by ilp_front, ilp_back, ilp_outq and integer_literal_parser; no dependencies
package ilp_pkg;

    localparam int unsigned ChW    = 8;
    localparam int unsigned ValueW = 64;
    localparam int unsigned CountW = 9;
    localparam int unsigned MaxW   = 8;
    localparam int unsigned DvalW  = 5;

    localparam logic [ChW-1:0]    CH_END       = 8'h00;
    localparam logic [ChW-1:0]    CH_ZERO      = 8'h30;
    localparam logic [ChW-1:0]    CH_NINE      = 8'h39;
    localparam logic [ChW-1:0]    CH_LOWER_A   = 8'h61;
    localparam logic [ChW-1:0]    CH_LOWER_F   = 8'h66;
    localparam logic [ChW-1:0]    CH_UPPER_A   = 8'h41;
    localparam logic [ChW-1:0]    CH_UPPER_F   = 8'h46;
    localparam logic [ChW-1:0]    CH_LOWER_X   = 8'h78;
    localparam logic [ChW-1:0]    CH_UPPER_X   = 8'h58;
    localparam logic [DvalW-1:0]  DVAL_NONE    = 5'd16;
    localparam logic [MaxW-1:0]   MAX_DIGITS_RST = 8'd20;

    localparam logic CFG_PARSE_MODE = 1'b0;
    localparam logic CFG_MAX_DIGITS = 1'b1;

    typedef enum logic [1:0] {
        MODE_AUTO = 2'd0,
        MODE_DEC  = 2'd1,
        MODE_OCT  = 2'd2,
        MODE_HEX  = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        RX_DEC = 2'd0,
        RX_OCT = 2'd1,
        RX_HEX = 2'd2
    } t_radix;

    typedef enum logic [2:0] {
        PH_IDLE      = 3'd0,
        PH_ZERO_AUTO = 3'd1,
        PH_ZERO_OCT  = 3'd2,
        PH_ZERO_HEX  = 3'd3,
        PH_AFTER_X   = 3'd4,
        PH_DIGITS    = 3'd5
    } t_phase;

    typedef enum logic [1:0] {
        ACT_NONE   = 2'd0,
        ACT_PREFIX = 2'd1,
        ACT_TAKE   = 2'd2,
        ACT_FINISH = 2'd3
    } t_act;

    typedef struct packed {
        logic [ChW-1:0] ch;
        logic           first;
    } t_in;

    typedef struct packed {
        logic signed [ValueW-1:0] value;
        logic [CountW-1:0]        consumed;
    } t_out;

    // classified character with the configuration sampled at accept
    typedef struct packed {
        logic             first;
        logic             is_end;
        logic             is_zero;
        logic             is_x;
        logic             is_dec;
        logic [DvalW-1:0] dval;
        t_mode            mode;
        logic [MaxW-1:0]  max_digits;
    } t_cls;

endpackage

### hw/rtl/ilp_front.sv
// ilp_front: configuration registers, character classifier and two-entry item queue
// depends on ilp_pkg
module ilp_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  push,
    output logic                  full,
    input  ilp_pkg::t_in          i_item,
    input  logic                  i_cfg_we,
    input  logic                  i_cfg_idx,
    input  logic [7:0]            i_cfg_wdata,
    output logic                  o_valid,
    input  logic                  i_ready,
    output ilp_pkg::t_cls         o_cls
);

    ilp_pkg::t_mode               r_mode;
    logic [ilp_pkg::MaxW-1:0]     r_max;
    ilp_pkg::t_cls                r_mem [2];
    logic                         r_wp;
    logic                         r_rp;
    logic [1:0]                   r_count;
    logic [1:0]                   n_count;
    ilp_pkg::t_cls                cls;
    logic                         wr;
    logic                         rd;

    function automatic logic [ilp_pkg::DvalW-1:0] digit_value(input logic [ilp_pkg::ChW-1:0] c);
        logic [ilp_pkg::DvalW-1:0] d;
        d = ilp_pkg::DVAL_NONE;
        if (c >= ilp_pkg::CH_ZERO && c <= ilp_pkg::CH_NINE) begin
            d = ilp_pkg::DvalW'(c - ilp_pkg::CH_ZERO);
        end else if (c >= ilp_pkg::CH_LOWER_A && c <= ilp_pkg::CH_LOWER_F) begin
            d = ilp_pkg::DvalW'(c - ilp_pkg::CH_LOWER_A + 8'd10);
        end else if (c >= ilp_pkg::CH_UPPER_A && c <= ilp_pkg::CH_UPPER_F) begin
            d = ilp_pkg::DvalW'(c - ilp_pkg::CH_UPPER_A + 8'd10);
        end
        return d;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= ilp_pkg::MODE_AUTO;
            r_max  <= ilp_pkg::MAX_DIGITS_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                ilp_pkg::CFG_PARSE_MODE: r_mode <= ilp_pkg::t_mode'(i_cfg_wdata[1:0]);
                ilp_pkg::CFG_MAX_DIGITS: r_max  <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        cls.first      = i_item.first;
        cls.is_end     = (i_item.ch == ilp_pkg::CH_END);
        cls.is_zero    = (i_item.ch == ilp_pkg::CH_ZERO);
        cls.is_x       = (i_item.ch == ilp_pkg::CH_LOWER_X) || (i_item.ch == ilp_pkg::CH_UPPER_X);
        cls.is_dec     = (i_item.ch >= ilp_pkg::CH_ZERO) && (i_item.ch <= ilp_pkg::CH_NINE);
        cls.dval       = digit_value(i_item.ch);
        cls.mode       = r_mode;
        cls.max_digits = r_max;
    end

    assign full    = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_cls   = r_mem[r_rp];
    assign wr      = push && !full;
    assign rd      = o_valid && i_ready;

    always_comb begin
        n_count = r_count;
        case ({wr, rd})
            2'b10:   n_count = r_count + 2'd1;
            2'b01:   n_count = r_count - 2'd1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= 1'b0;
            r_rp    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            r_count <= n_count;
            if (wr) begin
                r_wp <= ~r_wp;
            end
            if (rd) begin
                r_rp <= ~r_rp;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_mem[r_wp] <= cls;
        end
    end

endmodule

### hw/rtl/ilp_back.sv
// ilp_back: parse state machine with the base-scaled digit accumulator
// depends on ilp_pkg
module ilp_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  ilp_pkg::t_cls i_cls,
    output logic          o_push,
    input  logic          i_full,
    output ilp_pkg::t_out o_result
);

    ilp_pkg::t_phase                r_phase;
    ilp_pkg::t_phase                n_phase;
    ilp_pkg::t_radix                r_radix;
    ilp_pkg::t_radix                n_radix;
    logic [ilp_pkg::ValueW-1:0]     r_acc;
    logic [ilp_pkg::ValueW-1:0]     n_acc;
    logic [ilp_pkg::CountW-1:0]     r_cnt;
    logic [ilp_pkg::CountW-1:0]     n_cnt;
    logic [ilp_pkg::MaxW-1:0]       r_dl;
    logic [ilp_pkg::MaxW-1:0]       n_dl;

    logic                           fire;
    logic                           done;
    ilp_pkg::t_act                  act;
    ilp_pkg::t_phase                pre_phase;
    ilp_pkg::t_radix                rx;
    logic [ilp_pkg::ValueW-1:0]     eff_acc;
    logic [ilp_pkg::CountW-1:0]     eff_cnt;
    logic [ilp_pkg::MaxW-1:0]       eff_dl;
    logic [ilp_pkg::CountW-1:0]     cnt_inc;
    logic [ilp_pkg::MaxW-1:0]       dl_dec;
    logic                           digit_ok;
    logic [ilp_pkg::ValueW-1:0]     prod;

    assign o_ready = !i_full;
    assign fire    = i_valid && !i_full;

    // action decode per transaction
    always_comb begin
        act       = ilp_pkg::ACT_NONE;
        pre_phase = ilp_pkg::PH_IDLE;
        rx        = r_radix;
        if (i_cls.first) begin
            if (i_cls.is_end) begin
                act = ilp_pkg::ACT_FINISH;
            end else begin
                case (i_cls.mode)
                    ilp_pkg::MODE_AUTO: begin
                        if (i_cls.is_zero) begin
                            act = ilp_pkg::ACT_PREFIX; pre_phase = ilp_pkg::PH_ZERO_AUTO;
                            rx = ilp_pkg::RX_OCT;
                        end else if (i_cls.is_x) begin
                            act = ilp_pkg::ACT_PREFIX; pre_phase = ilp_pkg::PH_AFTER_X;
                            rx = ilp_pkg::RX_HEX;
                        end else begin
                            act = ilp_pkg::ACT_TAKE; rx = ilp_pkg::RX_DEC;
                        end
                    end
                    ilp_pkg::MODE_DEC: begin
                        act = ilp_pkg::ACT_TAKE; rx = ilp_pkg::RX_DEC;
                    end
                    ilp_pkg::MODE_OCT: begin
                        if (i_cls.is_zero) begin
                            act = ilp_pkg::ACT_PREFIX; pre_phase = ilp_pkg::PH_ZERO_OCT;
                            rx = ilp_pkg::RX_OCT;
                        end else begin
                            act = ilp_pkg::ACT_TAKE; rx = ilp_pkg::RX_OCT;
                        end
                    end
                    default: begin
                        if (i_cls.is_zero) begin
                            act = ilp_pkg::ACT_PREFIX; pre_phase = ilp_pkg::PH_ZERO_HEX;
                            rx = ilp_pkg::RX_HEX;
                        end else if (i_cls.is_x) begin
                            act = ilp_pkg::ACT_PREFIX; pre_phase = ilp_pkg::PH_AFTER_X;
                            rx = ilp_pkg::RX_HEX;
                        end else begin
                            act = ilp_pkg::ACT_TAKE; rx = ilp_pkg::RX_HEX;
                        end
                    end
                endcase
            end
        end else begin
            case (r_phase)
                ilp_pkg::PH_ZERO_AUTO: begin
                    if (i_cls.is_dec) begin
                        act = ilp_pkg::ACT_TAKE;
                    end else if (i_cls.is_x) begin
                        act = ilp_pkg::ACT_PREFIX; pre_phase = ilp_pkg::PH_AFTER_X;
                        rx = ilp_pkg::RX_HEX;
                    end else begin
                        act = ilp_pkg::ACT_FINISH;
                    end
                end
                ilp_pkg::PH_ZERO_OCT: begin
                    act = i_cls.is_dec ? ilp_pkg::ACT_TAKE : ilp_pkg::ACT_FINISH;
                end
                ilp_pkg::PH_ZERO_HEX: begin
                    if (i_cls.is_x) begin
                        act = ilp_pkg::ACT_PREFIX; pre_phase = ilp_pkg::PH_AFTER_X;
                        rx = ilp_pkg::RX_HEX;
                    end else if (!i_cls.dval[ilp_pkg::DvalW-1]) begin
                        act = ilp_pkg::ACT_TAKE;
                    end else begin
                        act = ilp_pkg::ACT_FINISH;
                    end
                end
                ilp_pkg::PH_AFTER_X: begin
                    act = !i_cls.dval[ilp_pkg::DvalW-1] ? ilp_pkg::ACT_TAKE
                                                        : ilp_pkg::ACT_FINISH;
                end
                ilp_pkg::PH_DIGITS: act = ilp_pkg::ACT_TAKE;
                default:            act = ilp_pkg::ACT_NONE;
            endcase
        end
    end

    // datapath
    always_comb begin
        eff_acc = i_cls.first ? '0 : r_acc;
        eff_cnt = i_cls.first ? '0 : r_cnt;
        eff_dl  = i_cls.first ? i_cls.max_digits : r_dl;
        cnt_inc = eff_cnt + 9'd1;
        dl_dec  = eff_dl - 8'd1;
        case (rx)
            ilp_pkg::RX_DEC: digit_ok = (i_cls.dval < 5'd10);
            ilp_pkg::RX_OCT: digit_ok = (i_cls.dval < 5'd8);
            ilp_pkg::RX_HEX: digit_ok = !i_cls.dval[ilp_pkg::DvalW-1];
            default:         digit_ok = 1'b0;
        endcase
        prod = ((rx == ilp_pkg::RX_HEX) ? (eff_acc << 4) : (eff_acc << 3))
             + ((rx == ilp_pkg::RX_DEC) ? (eff_acc << 1) : '0)
             + ilp_pkg::ValueW'(i_cls.dval[3:0]);
    end

    // next state
    always_comb begin
        n_phase = r_phase;
        n_radix = r_radix;
        n_acc   = r_acc;
        n_cnt   = r_cnt;
        n_dl    = r_dl;
        done    = 1'b0;
        if (fire) begin
            n_acc = eff_acc;
            n_cnt = eff_cnt;
            n_dl  = eff_dl;
            case (act)
                ilp_pkg::ACT_PREFIX: begin
                    n_radix = rx;
                    n_cnt   = cnt_inc;
                    n_phase = pre_phase;
                end
                ilp_pkg::ACT_TAKE: begin
                    n_radix = rx;
                    if (eff_dl == '0 || !digit_ok) begin
                        done = 1'b1;
                    end else begin
                        n_acc = prod;
                        n_cnt = cnt_inc;
                        n_dl  = dl_dec;
                        done  = (dl_dec == '0);
                    end
                    n_phase = done ? ilp_pkg::PH_IDLE : ilp_pkg::PH_DIGITS;
                end
                ilp_pkg::ACT_FINISH: begin
                    done    = 1'b1;
                    n_phase = ilp_pkg::PH_IDLE;
                end
                default: n_phase = ilp_pkg::PH_IDLE;
            endcase
        end
    end

    // outputs
    always_comb begin
        o_push            = done;
        o_result.value    = n_acc;
        o_result.consumed = n_cnt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= ilp_pkg::PH_IDLE;
            r_radix <= ilp_pkg::RX_DEC;
            r_acc   <= '0;
            r_cnt   <= '0;
            r_dl    <= '0;
        end else begin
            r_phase <= n_phase;
            r_radix <= n_radix;
            r_acc   <= n_acc;
            r_cnt   <= n_cnt;
            r_dl    <= n_dl;
        end
    end

`ifndef SYNTHESIS
    a_digits_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == ilp_pkg::PH_DIGITS) |-> (r_dl != '0))
        else $error("digit phase with no digits left");
    a_after_x_hex: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == ilp_pkg::PH_AFTER_X) |-> (r_radix == ilp_pkg::RX_HEX))
        else $error("after x prefix without hex radix");
    a_zero_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == ilp_pkg::PH_ZERO_AUTO || r_phase == ilp_pkg::PH_ZERO_OCT ||
         r_phase == ilp_pkg::PH_ZERO_HEX) |-> (r_cnt == 9'd1))
        else $error("zero prefix phase with wrong count");
    a_push_fire: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |-> fire)
        else $error("result without a transaction");
`endif

endmodule

### hw/rtl/ilp_outq.sv
// ilp_outq: two-entry result queue in front of the result ports
// depends on ilp_pkg
module ilp_outq (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    output logic          o_full,
    input  ilp_pkg::t_out i_result,
    output logic          empty,
    input  logic          pop,
    output ilp_pkg::t_out o_result
);

    ilp_pkg::t_out r_mem [2];
    logic          r_wp;
    logic          r_rp;
    logic [1:0]    r_count;
    logic [1:0]    n_count;
    logic          wr;
    logic          rd;

    assign o_full   = (r_count == 2'd2);
    assign empty    = (r_count == 2'd0);
    assign o_result = r_mem[r_rp];
    assign wr       = i_push && !o_full;
    assign rd       = pop && !empty;

    always_comb begin
        case ({wr, rd})
            2'b10:   n_count = r_count + 2'd1;
            2'b01:   n_count = r_count - 2'd1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= 1'b0;
            r_rp    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            r_count <= n_count;
            if (wr) begin
                r_wp <= ~r_wp;
            end
            if (rd) begin
                r_rp <= ~r_rp;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_mem[r_wp] <= i_result;
        end
    end

endmodule

### hw/rtl/integer_literal_parser.sv
// integer_literal_parser: top level of the streaming integer literal parser
// depends on ilp_pkg, ilp_front, ilp_back, ilp_outq
//
// Takes one character per clock, unless full is high, and parses C-style integer literals in
// auto, decimal, octal or hex mode, giving one result (64-bit wrapped value and consumed
// character count) when a parse ends. The block sustains one character transaction per cycle
// while the result queue has room; the result is pushed into that queue in the transaction of
// the character that ends the parse. That rate is set by the parse stage, which does one
// base-scaled 64-bit shift-add per character. Two-entry queues sit between the classifier and
// the parse stage and in front of the result ports. Configuration must be written only while
// no transaction is in flight; it is sampled with each character.
module integer_literal_parser (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          push,
    output logic          full,
    input  ilp_pkg::t_in  i_item,
    output logic          empty,
    input  logic          pop,
    output ilp_pkg::t_out o_result,
    input  logic          i_cfg_we,
    input  logic          i_cfg_idx,
    input  logic [7:0]    i_cfg_wdata
);

    logic          cls_valid;
    logic          cls_ready;
    ilp_pkg::t_cls cls;
    logic          res_push;
    logic          res_full;
    ilp_pkg::t_out res;

    ilp_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_item      (i_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_valid     (cls_valid),
        .i_ready     (cls_ready),
        .o_cls       (cls)
    );

    ilp_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (cls_valid),
        .o_ready  (cls_ready),
        .i_cls    (cls),
        .o_push   (res_push),
        .i_full   (res_full),
        .o_result (res)
    );

    ilp_outq u_outq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (res_push),
        .o_full   (res_full),
        .i_result (res),
        .empty    (empty),
        .pop      (pop),
        .o_result (o_result)
    );

endmodule
